// File: design/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// shared widths, types and sequencer states of the min/max/mean block
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int MAX_RECORDS = 8192;
    localparam int VALUE_BITS  = 27;

    localparam int IDX_BITS  = $clog2(MAX_RECORDS);
    localparam int CNT_BITS  = $clog2(MAX_RECORDS + 1);
    localparam int SUM_BITS  = VALUE_BITS + IDX_BITS;
    localparam int ITER_BITS = $clog2(SUM_BITS + 1);

    localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_PAYLOAD    = 2 * IDX_BITS + VALUE_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_PAYLOAD + 7) / 8) * 8;

    // figures of one finished stream, handed from tracker to sequencer
    typedef struct packed {
        logic [IDX_BITS-1:0] min_idx;
        logic [IDX_BITS-1:0] max_idx;
        logic [SUM_BITS-1:0] total;
        logic [CNT_BITS-1:0] count;
    } stats_sum_t;

    typedef enum logic [0:0] {
        ST_ACCUM  = 1'b0,
        ST_DIVIDE = 1'b1
    } seq_state_t;

endpackage

// File: design/stream_min_max_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_min_max_mean
// running min/max positions and truncated mean over a stream of samples
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: value (27 bits); tlast: is_last
//  m_axis   | out       | tdata: min_index (13), max_index (13), mean_value (27)
//
//  each sample request is compared and accumulated in the tracker as it is taken
//  the last request of a stream starts the serial divider, which runs its SUM_BITS (40)
//  iterations through one subtractor and then moves the mean to the
//  output register; s_axis_tready is low for that span
//  the output register frees the input side: a result may wait for m_axis
//  while the next stream is accumulated; a new division holds its result
//  until the output register is free
//  reset clears all stream figures and drops m_axis_tvalid; no clearing pass
//  a stream longer than MAX_RECORDS keeps only its first MAX_RECORDS samples
//
module stream_min_max_mean
    import sms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [26:0] value
    input  logic                      s_axis_tlast,   // is_last
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // min_index, max_index, mean_value
);

    seq_state_t            state_reg, state_next;
    stats_sum_t            summary;
    logic                  in_fire;
    logic                  div_start;
    logic                  div_busy;
    logic [VALUE_BITS-1:0] quotient;
    logic                  out_free;
    logic                  load_out;

    logic [IDX_BITS-1:0]       min_idx_reg;
    logic [IDX_BITS-1:0]       max_idx_reg;
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign div_start = in_fire && s_axis_tlast;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // running figures of the current stream
    sms_stats u_stats
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_fire  (in_fire),
        .sample_value (s_axis_tdata[VALUE_BITS-1:0]),
        .sample_last  (s_axis_tlast),
        .summary      (summary)
    );

    // total / count, one bit per cycle
    sms_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (summary.total),
        .divisor  (summary.count),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // sequencer: accumulate samples, then run the divide
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                s_axis_tready = 1'b1;
                if (div_start)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                // divider is busy from the cycle after start
                if (!div_busy && out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // positions of the finished stream, kept while the mean is formed
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            min_idx_reg <= summary.min_idx;
            max_idx_reg <= summary.max_idx;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= OUT_TDATA_BITS'({quotient, max_idx_reg, min_idx_reg});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: design/sms_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_stats
// running min/max with positions, total and count over one stream
// ----------------------------------------------------------------------------
module sms_stats
    import sms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_fire,
    input  logic [VALUE_BITS-1:0] sample_value,
    input  logic                  sample_last,
    output stats_sum_t            summary
);

    logic [VALUE_BITS-1:0] min_val_reg, min_val_next;
    logic [VALUE_BITS-1:0] max_val_reg, max_val_next;
    logic [IDX_BITS-1:0]   min_idx_reg, min_idx_next;
    logic [IDX_BITS-1:0]   max_idx_reg, max_idx_next;
    logic [SUM_BITS-1:0]   total_reg, total_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  full;
    logic [IDX_BITS-1:0]   pos;

    assign full = (cnt_reg >= CNT_BITS'(MAX_RECORDS));
    assign pos  = cnt_reg[IDX_BITS-1:0];

    // values after folding in the current sample
    always_comb
    begin
        min_val_next = min_val_reg;
        max_val_next = max_val_reg;
        min_idx_next = min_idx_reg;
        max_idx_next = max_idx_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        if (!full)
        begin
            if (cnt_reg == '0)
            begin
                min_val_next = sample_value;
                max_val_next = sample_value;
                min_idx_next = '0;
                max_idx_next = '0;
            end
            else
            begin
                if (sample_value < min_val_reg)
                begin
                    min_val_next = sample_value;
                    min_idx_next = pos;
                end
                if (sample_value > max_val_reg)
                begin
                    max_val_next = sample_value;
                    max_idx_next = pos;
                end
            end
            total_next = total_reg + SUM_BITS'(sample_value);
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    assign summary.min_idx = min_idx_next;
    assign summary.max_idx = max_idx_next;
    assign summary.total   = total_next;
    assign summary.count   = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_val_reg <= '0;
            max_val_reg <= '0;
            min_idx_reg <= '0;
            max_idx_reg <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
        end
        else if (sample_fire)
        begin
            if (sample_last)
            begin
                // stream done, start over
                min_val_reg <= '0;
                max_val_reg <= '0;
                min_idx_reg <= '0;
                max_idx_reg <= '0;
                total_reg   <= '0;
                cnt_reg     <= '0;
            end
            else
            begin
                min_val_reg <= min_val_next;
                max_val_reg <= max_val_next;
                min_idx_reg <= min_idx_next;
                max_idx_reg <= max_idx_next;
                total_reg   <= total_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

endmodule

// File: design/sms_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_divider
// restoring divider, one quotient bit per cycle through one subtractor
// ----------------------------------------------------------------------------
module sms_divider
    import sms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [CNT_BITS-1:0]   divisor,
    output logic                  busy,
    output logic [VALUE_BITS-1:0] quotient
);

    logic [CNT_BITS-1:0]  rem_reg, rem_next;
    logic [SUM_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_BITS-1:0]  div_reg;
    logic [ITER_BITS-1:0] iter_reg;
    logic                 busy_reg;
    logic [CNT_BITS:0]    shifted;
    logic [CNT_BITS:0]    diff;
    logic                 fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SUM_BITS-1]};
        diff     = shifted - {1'b0, div_reg};
        fits     = (shifted >= {1'b0, div_reg});
        rem_next = fits ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
        quo_next = {quo_reg[SUM_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= ITER_BITS'(SUM_BITS);
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg - 1'b1;
            if (iter_reg == ITER_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[VALUE_BITS-1:0];

endmodule
